// File: rtl/brcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brcl_pkg;

  // Operation codes carried in the op field of an input item.
  localparam logic [1:0] OP_MAP  = 2'd0;
  localparam logic [1:0] OP_MODE = 2'd1;
  localparam logic [1:0] OP_MEM  = 2'd2;

  // Soft switch selector codes (address bits 1:0 when bit 2 is clear).
  localparam logic [1:0] SW_READ_RAM  = 2'd0;
  localparam logic [1:0] SW_WRITE_ROM = 2'd1;
  localparam logic [1:0] SW_OFF       = 2'd2;
  localparam logic [1:0] SW_RW_RAM    = 2'd3;

  localparam int unsigned NumSegs  = 8;
  localparam int unsigned SegW     = 3;
  localparam int unsigned BankW    = 4;
  localparam int unsigned OffsW    = 13;
  localparam int unsigned RawIdxW  = BankW + OffsW;

  // Segments with mode gating.
  localparam logic [SegW-1:0] SegD = 3'd6;
  localparam logic [SegW-1:0] SegE = 3'd7;

  localparam logic [7:0] StatusBase = 8'hC0;
  localparam logic [7:0] ModeReset  = 8'h01;

  // Command queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [1:0]  op;
    logic        is_write;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       responded;
  } out_t;

  // One classified command handed from the front to the back.
  typedef struct packed {
    logic               ram_en;
    logic               ram_wr;
    logic [RawIdxW-1:0] ram_idx;
    logic [7:0]         wdata;
    logic [7:0]         res_data;
    logic               responded;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/brcl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module brcl_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_data_i,
  input  wire logic          in_push_i,
  input  wire brcl_pkg::in_t in_data_i,
  output brcl_pkg::cmd_t     cmd_o
);
  import brcl_pkg::*;

  logic [7:0] seg_map_q [NumSegs];
  logic [7:0] seg_map_d [NumSegs];
  logic [NumSegs-1:0] seg_en_q, seg_en_d;
  logic [7:0] mode_q, mode_d;
  logic       off_zero_q, off_zero_d;
  logic       latch_q, latch_d;
  logic       apple_q, apple_d;

  logic [15:0]     a;
  logic [SegW-1:0] seg;
  logic [SegW-1:0] ind;
  logic            rd_ok;
  logic [7:0]      status;
  logic [7:0]      mode_rd;
  logic [2:0]      bank3;
  logic [7:0]      bank;
  logic            allow;
  logic [OffsW-1:0] offs;

  assign a   = in_data_i.address;
  assign seg = a[15:13];
  assign ind = a[6:4];

  // Status byte reported by a soft switch access, taken before the access.
  always_comb begin
    rd_ok  = (seg_map_q[SegD] != 8'd0) && (mode_q[1:0] != 2'b01);
    status = StatusBase;
    status[3] = off_zero_q;
    status[0] = mode_q[0];
    status[1] = (rd_ok == mode_q[0]);
  end

  always_comb begin
    mode_rd = mode_q | {a[7:4], 4'b0000};
    if (mode_rd[1:0] == 2'b00) mode_rd[1] = 1'b1;
  end

  assign bank3 = {a[3], a[1:0]};
  assign bank  = {4'b0000, bank3, 1'b0};

  // Memory access gating and the D000 window offset.
  always_comb begin
    offs = a[OffsW-1:0];
    if (seg < SegD) begin
      allow = 1'b1;
    end else if ((seg == SegD) && !a[12]) begin
      allow = 1'b0;
    end else begin
      allow = in_data_i.is_write ? mode_q[0] : (mode_q[1:0] != 2'b01);
      if ((seg == SegD) && !off_zero_q) offs = {1'b0, a[11:0]};
    end
    allow = allow && seg_en_q[seg];
  end

  always_comb begin
    seg_map_d  = seg_map_q;
    seg_en_d   = seg_en_q;
    mode_d     = mode_q;
    off_zero_d = off_zero_q;
    latch_d    = latch_q;
    apple_d    = apple_q;

    cmd_o           = '0;
    cmd_o.wdata     = in_data_i.write_data;
    cmd_o.ram_idx   = {seg_map_q[seg][BankW-1:0], offs};

    unique case (in_data_i.op)
      OP_MAP: begin
        if (in_data_i.is_write) begin
          seg_map_d[ind]  = a[7:0] & 8'h8F;
          seg_en_d[ind]   = a[7];
          cmd_o.responded = 1'b1;
        end else if (!apple_q) begin
          cmd_o.res_data  = (a[7:0] & 8'h70) | seg_map_q[ind];
          cmd_o.responded = 1'b1;
        end
      end
      OP_MODE: begin
        cmd_o.responded = 1'b1;
        if (apple_q) begin
          if (!in_data_i.is_write) cmd_o.res_data = status;
          off_zero_d = a[3];
          if (a[2]) begin
            seg_map_d[SegD] = bank;
            seg_map_d[SegE] = bank | 8'h01;
          end else begin
            unique case (a[1:0])
              SW_READ_RAM: begin
                seg_en_d[SegD] = 1'b1;
                seg_en_d[SegE] = 1'b1;
                mode_d  = {a[7:4], a[3], 3'b010};
                latch_d = 1'b0;
              end
              SW_WRITE_ROM: begin
                seg_en_d[SegD] = 1'b0;
                seg_en_d[SegE] = 1'b0;
                mode_d  = {a[7:4], a[3], 2'b00, latch_q};
                latch_d = 1'b1;
              end
              SW_OFF: begin
                seg_en_d[SegD] = 1'b0;
                seg_en_d[SegE] = 1'b0;
                mode_d  = {a[7:4], a[3], 3'b000};
                latch_d = 1'b0;
              end
              SW_RW_RAM: begin
                seg_en_d[SegD] = 1'b1;
                seg_en_d[SegE] = 1'b1;
                mode_d  = {a[7:4], a[3], 2'b01, latch_q};
                latch_d = 1'b1;
              end
              default: ;
            endcase
          end
        end else if (in_data_i.is_write) begin
          mode_d     = {4'b0000, a[3], 1'b0, a[1:0]};
          off_zero_d = a[3];
        end else begin
          cmd_o.res_data = mode_rd;
        end
      end
      OP_MEM: begin
        if (allow) begin
          cmd_o.ram_en    = 1'b1;
          cmd_o.ram_wr    = in_data_i.is_write;
          cmd_o.responded = 1'b1;
        end
      end
      default: ;
    endcase

    if (!in_push_i) begin
      seg_map_d  = seg_map_q;
      seg_en_d   = seg_en_q;
      mode_d     = mode_q;
      off_zero_d = off_zero_q;
      latch_d    = latch_q;
    end

    // Resets the mode state; users must write only while idle (not enforced).
    if (cfg_we_i) begin
      apple_d    = cfg_data_i;
      mode_d     = ModeReset;
      off_zero_d = 1'b0;
      seg_en_d   = '0;
      if (cfg_data_i) latch_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSegs; i++) begin
        seg_map_q[i] <= 8'(i);
      end
      seg_en_q   <= '0;
      mode_q     <= ModeReset;
      off_zero_q <= 1'b0;
      latch_q    <= 1'b0;
      apple_q    <= 1'b0;
    end else begin
      seg_map_q  <= seg_map_d;
      seg_en_q   <= seg_en_d;
      mode_q     <= mode_d;
      off_zero_q <= off_zero_d;
      latch_q    <= latch_d;
      apple_q    <= apple_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/brcl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module brcl_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire brcl_pkg::cmd_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output brcl_pkg::cmd_t      pop_data_o,
  output logic                empty_o
);
  import brcl_pkg::*;

  cmd_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// File: rtl/brcl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module brcl_back #(
  parameter int unsigned RAM_BYTES = 131072
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire brcl_pkg::cmd_t cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output brcl_pkg::out_t      out_data_o
);
  import brcl_pkg::*;

  localparam int unsigned AddrW = $clog2(RAM_BYTES);

  logic [7:0] mem [RAM_BYTES];

  logic [RawIdxW-1:0] idx_red;
  logic [AddrW-1:0]   addr;
  logic               out_valid_q;
  logic               sel_ram_q;
  logic [7:0]         res_q;
  logic               resp_q;
  logic [7:0]         ram_rd_q;

  // The raw bank address is below twice the RAM size, so one subtract wraps it.
  always_comb begin
    idx_red = cmd_i.ram_idx;
    if ({1'b0, cmd_i.ram_idx} >= (RawIdxW + 1)'(RAM_BYTES)) begin
      idx_red = cmd_i.ram_idx - RawIdxW'(RAM_BYTES);
    end
  end
  assign addr = idx_red[AddrW-1:0];

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.ram_en) begin
      if (cmd_i.ram_wr) mem[addr] <= cmd_i.wdata;
      else ram_rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sel_ram_q <= cmd_i.ram_en && !cmd_i.ram_wr;
      res_q     <= cmd_i.res_data;
      resp_q    <= cmd_i.responded;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.read_data = sel_ram_q ? ram_rd_q : res_q;
  assign out_data_o.responded = resp_q;

endmodule

`default_nettype wire

// File: rtl/banked_ram_card_with_language_mode_top.sv
// Bank-switched RAM card with a language-card style control mode.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one bus access
// per transfer: a mapping register access, a mode register access or a CPU
// memory access. Output channel (out_valid_o / out_ready_i / out_data_o)
// returns exactly one result per access, in order: read data and a flag that
// tells whether the card answered. The configuration channel (cfg_valid_i /
// cfg_ready_o / cfg_data_i) writes apple_mode; it is always ready and must be
// used only while no access is in flight.
// An access is written into the command queue at its input transfer, and the
// back end then loads its result into the result register, from which the
// result can transfer.
// Throughput is one access per cycle while the receiver is ready, set by the
// single-port RAM that serves one read or write per cycle in the back end.
// Reset restores the identity mapping with all segments disabled; RAM is
// not cleared. The user must read only written RAM; the card won't check.
// When the receiver stalls, the result register holds, the two-entry command
// queue fills, and in_ready_o drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module banked_ram_card_with_language_mode_top #(
  parameter int unsigned RAM_BYTES = 131072
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic           cfg_data_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire brcl_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output brcl_pkg::out_t      out_data_o
);
  import brcl_pkg::*;

  logic cfg_we;
  logic push;
  logic full;
  logic empty;
  logic pop;
  cmd_t cmd_in;
  cmd_t cmd_out;

  // Configuration writes are accepted every cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // The front end takes an access whenever the queue has room.
  assign in_ready_o = !full;
  assign push       = in_valid_i && in_ready_o;

  // The front end decodes each access, updates mapping and mode state, and
  // turns memory accesses into a RAM command.
  brcl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .in_push_i  (push),
    .in_data_i  (in_data_i),
    .cmd_o      (cmd_in)
  );

  brcl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd_in),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (cmd_out),
    .empty_o     (empty)
  );

  // The back end performs the RAM access and holds the result for transfer.
  brcl_back #(
    .RAM_BYTES (RAM_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/brcl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module brcl_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           cfg_valid_i,
  input wire logic           cfg_ready_o,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire brcl_pkg::out_t out_data_o
);
  import brcl_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An unanswered access never carries data.
  a_no_resp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.responded |-> out_data_o.read_data == 8'd0)
    else $error("unanswered access returned data");

  // Leaving reset, no result is pending and the input side is open.
  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("state not clean after reset");

  // The configuration port never back-pressures.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind banked_ram_card_with_language_mode_top brcl_checker u_brcl_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import brcl_pkg::*;

  // The card serves 16 banks of 8 KB, so a bank index never wraps the RAM.
  localparam int unsigned CardBytes  = 131072;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0]  OpUnused   = 2'd3;

  // An access waiting for the driver. The expected result is worked out while
  // the item is queued, because the stimulus must know the card state to avoid
  // reading RAM that was never written. The result only becomes an expectation
  // once the access has been transferred into the card.
  typedef struct {
    in_t  item;
    out_t result;
    bit   hold;  // wait for every outstanding result before sending
  } access_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_data_i  = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic cfg_ready_o;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  access_t pending_accesses[$];
  out_t    expected_results[$];
  logic [15:0] written_addrs[$];
  out_t    inflight_result;
  access_t next_access;
  out_t    seen_result;
  int      errors      = 0;
  int      gap_pct     = 20;
  int      cycle_count = 0;

  // Mirror of the card state.
  bit          lc_mode;
  logic [7:0]  seg_map[8];
  bit          seg_en[8];
  logic [7:0]  mode_q;
  bit          offs_zero;
  bit          wr_latch;
  logic [7:0]  ram_img[CardBytes];
  bit          ram_seen[CardBytes];

  banked_ram_card_with_language_mode_top #(
    .RAM_BYTES(CardBytes)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Decides whether a memory access reaches RAM, and at which byte. Segments
  // 6 and 7 are gated by the mode bits: bit 0 allows writes, and reads are
  // allowed unless the two low mode bits read as 1. C000-CFFF is never served.
  // Without offset_zero, D000-DFFF is moved down by 0x1000 before mapping.
  function automatic void route_mem(input in_t it, output bit hit, output logic [16:0] idx);
    logic [2:0]  seg;
    logic [15:0] eff;
    bit          allow;
    seg = it.address[15:13];
    eff = it.address;
    hit = 1'b0;
    idx = '0;
    if (seg_en[seg]) begin
      if (seg < SegD) begin
        allow = 1'b1;
      end else if (seg == SegD && it.address < 16'hD000) begin
        allow = 1'b0;
      end else begin
        allow = it.is_write ? mode_q[0] : (mode_q[1:0] != 2'b01);
        if (seg == SegD && !offs_zero) eff = it.address - 16'h1000;
      end
      if (allow) begin
        hit = 1'b1;
        idx = {seg_map[eff[15:13]][3:0], eff[12:0]};
      end
    end
  endfunction

  // Status byte that a soft switch access returns, taken before the access.
  function automatic logic [7:0] status_now();
    logic [7:0] s;
    bit         wr_on;
    bit         rd_on;
    s     = StatusBase;
    wr_on = mode_q[0];
    rd_on = (seg_map[SegD] != 8'd0) && (mode_q[1:0] != 2'b01);
    if (offs_zero) s[3] = 1'b1;
    if (wr_on) s[0] = 1'b1;
    if (rd_on == wr_on) s[1] = 1'b1;
    return s;
  endfunction

  // Language-card soft switches. Address bit 3 selects the offset and the
  // high bank half, bit 2 selects a bank pair, otherwise bits 1:0 pick the
  // read/write setup. A write enable needs two accesses in a row, which the
  // last-write latch tracks.
  function automatic logic [7:0] flip_switch(input logic [15:0] a);
    logic [7:0] prev;
    logic [7:0] hi;
    logic [7:0] top;
    logic [7:0] bank;
    prev      = status_now();
    hi        = {4'd0, a[3], 3'd0};
    top       = {a[7:4], 4'd0};
    offs_zero = a[3];
    if (a[2]) begin
      bank         = {4'd0, a[3], a[1:0], 1'b0};
      seg_map[SegD] = bank;
      seg_map[SegE] = bank + 8'd1;
    end else begin
      case (a[1:0])
        SW_READ_RAM: begin
          seg_en[SegD] = 1'b1;
          seg_en[SegE] = 1'b1;
          mode_q       = 8'h02 | hi | top;
          wr_latch     = 1'b0;
        end
        SW_WRITE_ROM: begin
          seg_en[SegD] = 1'b0;
          seg_en[SegE] = 1'b0;
          mode_q       = {7'd0, wr_latch} | hi | top;
          wr_latch     = 1'b1;
        end
        SW_OFF: begin
          seg_en[SegD] = 1'b0;
          seg_en[SegE] = 1'b0;
          mode_q       = hi | top;
          wr_latch     = 1'b0;
        end
        default: begin
          seg_en[SegD] = 1'b1;
          seg_en[SegE] = 1'b1;
          mode_q       = 8'h02 | {7'd0, wr_latch} | hi | top;
          wr_latch     = 1'b1;
        end
      endcase
    end
    return prev;
  endfunction

  // Applies one access to the mirrored state and returns what the card answers.
  function automatic out_t card_access(input in_t it);
    out_t        r;
    logic [2:0]  ind;
    logic [7:0]  prev;
    logic [7:0]  m;
    bit          hit;
    logic [16:0] idx;
    r = '0;
    case (it.op)
      OP_MAP: begin
        ind = it.address[6:4];
        if (it.is_write) begin
          seg_map[ind] = it.address[7:0] & 8'h8F;
          seg_en[ind]  = it.address[7];
          r.responded  = 1'b1;
        end else if (!lc_mode) begin
          r.read_data = (it.address[7:0] & 8'h70) | seg_map[ind];
          r.responded = 1'b1;
        end
      end
      OP_MODE: begin
        if (lc_mode) begin
          prev = flip_switch(it.address);
          if (!it.is_write) r.read_data = prev;
          r.responded = 1'b1;
        end else if (it.is_write) begin
          mode_q      = it.address[7:0] & 8'h0B;
          offs_zero   = mode_q[3];
          r.responded = 1'b1;
        end else begin
          m = mode_q | (it.address[7:0] & 8'hF0);
          if (m[1:0] == 2'b00) m[1] = 1'b1;
          r.read_data = m;
          r.responded = 1'b1;
        end
      end
      OP_MEM: begin
        route_mem(it, hit, idx);
        if (hit) begin
          if (it.is_write) begin
            ram_img[idx]  = it.write_data;
            ram_seen[idx] = 1'b1;
          end else begin
            r.read_data = ram_img[idx];
          end
          r.responded = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Queues one access. A read that would land on a RAM byte never written is
  // turned into a write of the same address, which keeps the stimulus inside
  // what the card promises.
  task automatic queue_access(input logic [1:0] op, input bit wr, input logic [15:0] addr,
                              input logic [7:0] data, input bit hold = 1'b0);
    access_t     acc;
    bit          hit;
    logic [16:0] idx;
    acc.item = '{op: op, is_write: wr, address: addr, write_data: data};
    acc.hold = hold;
    if (op == OP_MEM && !wr) begin
      route_mem(acc.item, hit, idx);
      if (hit && !ram_seen[idx]) acc.item.is_write = 1'b1;
    end
    if (op == OP_MEM && acc.item.is_write) begin
      written_addrs.push_back(addr);
      if (written_addrs.size() > 32) void'(written_addrs.pop_front());
    end
    acc.result = card_access(acc.item);
    pending_accesses.push_back(acc);
  endtask

  // Returns once every queued access has been transferred and answered.
  task automatic wait_card_idle();
    while (pending_accesses.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Writes apple_mode through the configuration channel and mirrors the side
  // effects: mode bits and offset back to reset, every segment disabled, and
  // the write latch cleared when entering language-card mode.
  task automatic write_apple_mode(input bit value);
    int i;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lc_mode   = value;
    mode_q    = ModeReset;
    offs_zero = 1'b0;
    for (i = 0; i < NumSegs; i++) seg_en[i] = 1'b0;
    if (value) wr_latch = 1'b0;
  endtask

  // Driver: presents the oldest queued access and holds it until the card
  // takes it. A transfer at this edge turns the access into an expectation.
  // Gaps are drawn at random; an access marked hold waits for the card to
  // drain completely first.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) expected_results.push_back(inflight_result);
      if (!in_valid_i || in_ready_o) begin
        if (pending_accesses.size() != 0 && $urandom_range(99) >= gap_pct &&
            !(pending_accesses[0].hold && expected_results.size() != 0)) begin
          next_access     = pending_accesses.pop_front();
          inflight_result = next_access.result;
          in_valid_i      <= 1'b1;
          in_data_i       <= next_access.item;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is compared field by field with the oldest
  // expectation. The receiver stalls at random at the same rate as the sender.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result read_data %h responded %b", $time,
                   out_data_o.read_data, out_data_o.responded);
          errors++;
        end else begin
          seen_result = expected_results.pop_front();
          if (out_data_o.read_data !== seen_result.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time,
                     seen_result.read_data, out_data_o.read_data);
            errors++;
          end
          if (out_data_o.responded !== seen_result.responded) begin
            $display("%0t: responded expected %b actual %b", $time,
                     seen_result.responded, out_data_o.responded);
            errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= gap_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int          i;
    int          phase;
    int          n;
    int          r;
    int          pick;
    logic [1:0]  op;
    bit          wr;
    logic [15:0] addr;
    logic [7:0]  data;

    // Reset image of the card: identity mapping, all segments off.
    lc_mode   = 1'b0;
    mode_q    = ModeReset;
    offs_zero = 1'b0;
    wr_latch  = 1'b0;
    for (i = 0; i < NumSegs; i++) begin
      seg_map[i] = 8'(i);
      seg_en[i]  = 1'b0;
    end
    for (i = 0; i < CardBytes; i++) ram_seen[i] = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Native registers: unused op, mapping readback, gated and ungated memory,
    // the offset in D000-DFFF, the hole at C000-CFFF and the read release
    // at E000 and FFFF.
    write_apple_mode(1'b0);
    queue_access(OpUnused, 1'b0, 16'hFFFF, 8'hFF);
    queue_access(OpUnused, 1'b1, 16'h0000, 8'h00);
    queue_access(OP_MAP,   1'b0, 16'h0070, 8'h00);
    queue_access(OP_MEM,   1'b1, 16'h0000, 8'h5A);
    queue_access(OP_MAP,   1'b1, 16'h0080, 8'h00);
    queue_access(OP_MAP,   1'b1, 16'h00FF, 8'h00);
    queue_access(OP_MAP,   1'b1, 16'h00EE, 8'h00);
    queue_access(OP_MEM,   1'b1, 16'h0000, 8'h00);
    queue_access(OP_MEM,   1'b1, 16'h1FFF, 8'hFF);
    queue_access(OP_MEM,   1'b0, 16'h1FFF, 8'h00);
    queue_access(OP_MEM,   1'b1, 16'hFFFF, 8'hA5);
    queue_access(OP_MEM,   1'b0, 16'hFFFF, 8'h00);
    queue_access(OP_MODE,  1'b1, 16'hFF0B, 8'h00);
    queue_access(OP_MEM,   1'b1, 16'hD000, 8'h3C);
    queue_access(OP_MEM,   1'b0, 16'hFFFF, 8'h00);
    queue_access(OP_MEM,   1'b0, 16'hC000, 8'h00);
    queue_access(OP_MODE,  1'b1, 16'h0000, 8'h00);
    queue_access(OP_MODE,  1'b0, 16'h00F0, 8'h00);
    queue_access(OP_MEM,   1'b0, 16'hE000, 8'h00);
    wait_card_idle();

    // Language-card switches: the double access that opens writes, bank pair
    // selection, write-protect and off, and mapping reads left unanswered.
    write_apple_mode(1'b1);
    queue_access(OP_MAP,  1'b0, 16'h0000, 8'h00);
    queue_access(OP_MODE, 1'b0, 16'hC08B, 8'h00);
    queue_access(OP_MODE, 1'b0, 16'hC08B, 8'h00);
    queue_access(OP_MEM,  1'b1, 16'hD000, 8'h77);
    queue_access(OP_MEM,  1'b0, 16'hD000, 8'h00);
    queue_access(OP_MODE, 1'b1, 16'hC08F, 8'h00);
    queue_access(OP_MODE, 1'b0, 16'hC080, 8'h00);
    queue_access(OP_MEM,  1'b0, 16'hFFFF, 8'h00);
    queue_access(OP_MODE, 1'b0, 16'hC081, 8'h00);
    queue_access(OP_MODE, 1'b0, 16'hC082, 8'h00);
    wait_card_idle();

    // Random phases alternate the two settings. One phase runs without any
    // gaps on either side; now and then an access waits for the card to drain.
    for (phase = 0; phase < 4; phase++) begin
      write_apple_mode(phase[0]);
      gap_pct = (phase == 2) ? 0 : 20;
      for (n = 0; n < 400; n++) begin
        r    = $urandom_range(99);
        addr = 16'($urandom);
        data = 8'($urandom);
        wr   = 1'($urandom_range(1));
        op   = OP_MEM;
        if (r < 8) begin
          // Mapping writes mostly enable the segment they touch.
          op = OP_MAP;
          wr = 1'b1;
          if ($urandom_range(4) != 0) addr[7] = 1'b1;
        end else if (r < 12) begin
          op = OP_MAP;
        end else if (r < 22) begin
          op = OP_MODE;
        end else if (r < 24) begin
          op = OpUnused;
        end else begin
          // Memory traffic revisits recent addresses so that reads find data.
          pick = $urandom_range(9);
          if (pick < 6 && written_addrs.size() != 0)
            addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
          else if (pick < 8)
            addr[15:14] = 2'b11;
        end
        queue_access(op, wr, addr, data, $urandom_range(149) == 0);
      end
      wait_card_idle();
    end

    gap_pct = 20;
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
